### sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the Gram-Schmidt core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define GSQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define GSQ_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/gsq_pkg.sv
// Shared constants, types and fixed-point helpers of the Gram-Schmidt core.
`timescale 1ns / 1ps
package gsq_pkg;

	localparam int MAX_DIM    = 8;
	localparam int DIM_W      = $clog2(MAX_DIM);
	localparam int ENTRIES    = MAX_DIM * MAX_DIM;
	localparam int ADDR_W     = $clog2(ENTRIES);
	localparam int N_W        = 4;
	localparam int LOAD_W     = ADDR_W + 1;
	localparam int DATA_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;
	localparam int DIV_STEPS  = 63;
	localparam int DIV_CNT_W  = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIN_DEP     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd2;

	localparam logic signed [DATA_W-1:0] QONE    = 32'sh0001_0000;
	localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;
	localparam logic signed [64:0] WIDE_MAX = 65'sd2147483647;
	localparam logic signed [64:0] WIDE_MIN = -65'sd2147483648;

	typedef struct packed {
		logic                     ovf;
		logic signed [DATA_W-1:0] val;
	} sat_t;

	typedef struct packed {
		logic                     start;
		logic signed [63:0]       dividend;
		logic signed [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic                     ovf;
		logic signed [DATA_W-1:0] quot;
	} div_rsp_t;

	function automatic sat_t sat65(input logic signed [64:0] v);
		sat_t r;
		if (v > WIDE_MAX) begin
			r.ovf = 1'b1;
			r.val = SAT_MAX;
		end else if (v < WIDE_MIN) begin
			r.ovf = 1'b1;
			r.val = SAT_MIN;
		end else begin
			r.ovf = 1'b0;
			r.val = v[DATA_W-1:0];
		end
		return r;
	endfunction

	// Q32.32 product back to Q16.16, truncated toward zero.
	function automatic sat_t qscale(input logic signed [63:0] p);
		logic signed [47:0] t;
		logic signed [64:0] w;
		t = p[63:16];
		if (p[63] && (p[15:0] != 16'd0))
			t = t + 48'sd1;
		w = {{17{t[47]}}, t};
		return sat65(w);
	endfunction

	function automatic sat_t qadd(input logic signed [DATA_W-1:0] a,
	                              input logic signed [DATA_W-1:0] b);
		logic signed [64:0] w;
		w = $signed({{33{a[31]}}, a}) + $signed({{33{b[31]}}, b});
		return sat65(w);
	endfunction

	function automatic sat_t qsub(input logic signed [DATA_W-1:0] a,
	                              input logic signed [DATA_W-1:0] b);
		logic signed [64:0] w;
		w = $signed({{33{a[31]}}, a}) - $signed({{33{b[31]}}, b});
		return sat65(w);
	endfunction

endpackage

### sv/gsq_ifs.sv
// Stream and configuration channel interfaces of the Gram-Schmidt core.
`timescale 1ns / 1ps
interface gsq_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [gsq_pkg::DATA_W-1:0]  gram_entry;
	logic                               last_entry;
	modport source (output valid, gram_entry, last_entry, input ready);
	modport sink   (input valid, gram_entry, last_entry, output ready);
endinterface

interface gsq_out_if;
	logic                               valid;
	logic                               ready;
	logic [gsq_pkg::DIM_W-1:0]          row_index;
	logic [gsq_pkg::DIM_W-1:0]          col_index;
	logic signed [gsq_pkg::DATA_W-1:0]  r_value;
	logic signed [gsq_pkg::DATA_W-1:0]  c_value;
	logic                               overflow;
	logic                               last_result;
	modport source (output valid, row_index, col_index, r_value, c_value, overflow,
	                last_result, input ready);
	modport sink   (input valid, row_index, col_index, r_value, c_value, overflow,
	                last_result, output ready);
endinterface

interface gsq_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [gsq_pkg::CFG_IDX_W-1:0]       index;
	logic [gsq_pkg::CFG_DATA_W-1:0]      data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### sv/gram_schmidt_qr_from_gram_matrix_core.sv
// Top level of the Gram-Schmidt QR core: loads an N x N Gram matrix in Q16.16
// and emits the unnormalized factors R and C. Each accepted beat writes one
// entry into the Gram memory (up to 64 entries); the beat with last_entry set
// starts the run, and no input is taken until all N*N result beats have been
// handed to the output register. R and C share one 64-entry memory (R in the
// upper half of each word, C in the lower), with per-entry valid bits that
// make unwritten entries read as zero and identity, so there is no clearing
// pass after reset or between runs. The run is set by a sequencer doing one
// memory read per step: every multiply-accumulate of R goes through the read,
// multiply, scale and accumulate states, each division term of C waits on the
// bit-serial divider (63 steps plus handling), and each result beat waits on
// any output stall. For N = 8 there are 84 division terms. The overflow bit
// is the same on every beat of a run and covers any saturation or zero
// divisor met in it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gram_schmidt_qr_from_gram_matrix_core (
	input  logic        clk,
	input  logic        arst_n,
	gsq_in_if.sink      gram_in,
	gsq_out_if.source   res_out,
	gsq_cfg_if.sink     cfg
);

	localparam int DW = gsq_pkg::DATA_W;
	localparam int XW = gsq_pkg::DIM_W;
	localparam int AW = gsq_pkg::ADDR_W;

	// sequencer codes
	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_INIT    = 5'd1;
	localparam logic [4:0] ST_R00     = 5'd2;
	localparam logic [4:0] ST_P1_RD   = 5'd3;
	localparam logic [4:0] ST_P1_MUL  = 5'd4;
	localparam logic [4:0] ST_P1_SCL  = 5'd5;
	localparam logic [4:0] ST_P1_ACC  = 5'd6;
	localparam logic [4:0] ST_P2_RDD  = 5'd7;
	localparam logic [4:0] ST_P2_CHK  = 5'd8;
	localparam logic [4:0] ST_P2_GA   = 5'd9;
	localparam logic [4:0] ST_P2_GB   = 5'd10;
	localparam logic [4:0] ST_P2_DIV  = 5'd11;
	localparam logic [4:0] ST_P2_DWT  = 5'd12;
	localparam logic [4:0] ST_P2_SUB  = 5'd13;
	localparam logic [4:0] ST_P2_NXT  = 5'd14;
	localparam logic [4:0] ST_P3_RD   = 5'd15;
	localparam logic [4:0] ST_P3_MUL  = 5'd16;
	localparam logic [4:0] ST_P3_SCL  = 5'd17;
	localparam logic [4:0] ST_P3_ACC  = 5'd18;
	localparam logic [4:0] ST_P3_RDL  = 5'd19;
	localparam logic [4:0] ST_P3_MUL2 = 5'd20;
	localparam logic [4:0] ST_P3_SCL2 = 5'd21;
	localparam logic [4:0] ST_P3_ACC2 = 5'd22;
	localparam logic [4:0] ST_EM_RD   = 5'd23;
	localparam logic [4:0] ST_EM_WT   = 5'd24;

	// config registers
	logic [gsq_pkg::N_W-1:0]        size_q;
	logic                           lindep_q;
	logic [gsq_pkg::CFG_DATA_W-1:0] thr_q;

	logic [4:0]                     state_q;
	logic [gsq_pkg::LOAD_W-1:0]     cnt_q;
	logic [gsq_pkg::N_W-1:0]        n_q;
	logic [XW-1:0]                  k_q, i_q, j_q, l_q, p_q, row_q, col_q;
	logic signed [DW-1:0]           acc_q, rkk_q, mq_q, a_q, d_q, q_q;
	logic                           ov_q;

	// memories and their read pipeline
	logic signed [DW-1:0]           gram_mem [gsq_pkg::ENTRIES];
	logic [2*DW-1:0]                rc_mem   [gsq_pkg::ENTRIES];
	logic [gsq_pkg::ENTRIES-1:0]    r_vld_q, c_vld_q;
	logic signed [DW-1:0]           gram_rd_s1;
	logic [2*DW-1:0]                rc_rd_s1;
	logic                           rv_s1, cv_s1, dg_s1;
	logic signed [63:0]             prod_s1;

	// output register
	logic                           out_vld_q;
	logic [XW-1:0]                  orow_q, ocol_q;
	logic signed [DW-1:0]           or_q, oc_q;
	logic                           oov_q, olast_q;

	gsq_pkg::div_req_t              div_req;
	gsq_pkg::div_rsp_t              div_rsp;

	logic                           in_acc;
	logic [XW-1:0]                  nm1, km1;
	logic [AW-1:0]                  gaddr, raddr, waddr;
	logic [6:0]                     gprod;
	logic [XW-1:0]                  gcol;
	logic                           we_r, we_c;
	logic signed [DW-1:0]           wr_r, wr_c;
	logic signed [DW-1:0]           r_eff, c_eff;
	logic [32:0]                    dmag;
	logic                           skip;
	logic                           out_free;
	logic                           em_last;
	gsq_pkg::sat_t                  qs, sa, sk, ss;

	assign in_acc        = gram_in.valid && gram_in.ready;
	assign gram_in.ready = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign nm1           = XW'(n_q - 1'b1);
	assign km1           = XW'(k_q - 1'b1);
	assign out_free      = !out_vld_q || res_out.ready;
	assign em_last       = (row_q == nm1) && (col_q == nm1);

	// effective operands: unwritten entries read as R = 0, C = identity
	always_comb begin
		r_eff = rv_s1 ? rc_rd_s1[2*DW-1:DW] : '0;
		c_eff = cv_s1 ? rc_rd_s1[DW-1:0] : (dg_s1 ? gsq_pkg::QONE : '0);
		dmag  = r_eff[DW-1] ? 33'(-$signed({r_eff[DW-1], r_eff})) : {1'b0, r_eff};
		skip  = lindep_q && (dmag < {2'b00, thr_q});
		qs    = gsq_pkg::qscale(prod_s1);
		sa    = gsq_pkg::qadd(acc_q, mq_q);
		sk    = gsq_pkg::qadd(rkk_q, mq_q);
		ss    = gsq_pkg::qsub(acc_q, q_q);
	end

	// read addresses
	always_comb begin
		gcol  = (state_q == ST_P3_RD) ? p_q : k_q;
		gprod = 7'(l_q) * 7'(n_q) + 7'(gcol);
		gaddr = (state_q == ST_INIT) ? '0 : gprod[AW-1:0];
		case (state_q)
			ST_P1_RD:  raddr = {l_q, i_q};
			ST_P2_RDD: raddr = {i_q, i_q};
			ST_P2_CHK: raddr = {i_q, k_q};
			ST_P2_GA:  raddr = {j_q, i_q};
			ST_P3_RD:  raddr = {p_q, k_q};
			ST_P3_RDL: raddr = {l_q, k_q};
			default:   raddr = {row_q, col_q};
		endcase
	end

	// write port
	always_comb begin
		we_r  = 1'b0;
		we_c  = 1'b0;
		waddr = '0;
		wr_r  = sa.val;
		wr_c  = acc_q;
		case (state_q)
			ST_R00: begin
				we_r = 1'b1;
				wr_r = gram_rd_s1;
			end
			ST_P1_ACC: begin
				we_r  = (l_q == i_q);
				waddr = {i_q, k_q};
			end
			ST_P2_NXT: begin
				we_c  = (i_q == km1);
				waddr = {j_q, k_q};
			end
			ST_P3_ACC2: begin
				we_r  = (l_q == k_q);
				waddr = {k_q, k_q};
				wr_r  = sk.val;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc && (cnt_q < gsq_pkg::LOAD_W'(gsq_pkg::ENTRIES)))
			gram_mem[cnt_q[AW-1:0]] <= gram_in.gram_entry;
		gram_rd_s1 <= gram_mem[gaddr];
		if (we_r)
			rc_mem[waddr][2*DW-1:DW] <= wr_r;
		if (we_c)
			rc_mem[waddr][DW-1:0] <= wr_c;
		rc_rd_s1 <= rc_mem[raddr];
		rv_s1    <= r_vld_q[raddr];
		cv_s1    <= c_vld_q[raddr];
		dg_s1    <= (raddr[AW-1:XW] == raddr[XW-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_vld_q <= '0;
			c_vld_q <= '0;
		end else if (state_q == ST_INIT) begin
			r_vld_q <= '0;
			c_vld_q <= '0;
		end else begin
			if (we_r)
				r_vld_q[waddr] <= 1'b1;
			if (we_c)
				c_vld_q[waddr] <= 1'b1;
		end
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= 4'd4;
			lindep_q <= 1'b0;
			thr_q    <= 31'd1;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				gsq_pkg::CFG_MATRIX_SIZE: size_q   <= cfg.data[gsq_pkg::N_W-1:0];
				gsq_pkg::CFG_LIN_DEP:     lindep_q <= cfg.data[0];
				gsq_pkg::CFG_THRESHOLD:   thr_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	assign div_req.start    = (state_q == ST_P2_DIV);
	assign div_req.dividend = prod_s1;
	assign div_req.divisor  = d_q;

	gsq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// multiplier, always one register before any further use
	always_ff @(posedge clk) begin
		case (state_q)
			ST_P1_MUL, ST_P3_MUL: prod_s1 <= 64'(c_eff) * 64'(gram_rd_s1);
			ST_P3_MUL2:           prod_s1 <= 64'(c_eff) * 64'(acc_q);
			ST_P2_GB:             prod_s1 <= 64'(a_q) * 64'(c_eff);
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			n_q       <= 4'd4;
			ov_q      <= 1'b0;
			out_vld_q <= 1'b0;
			k_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
			l_q       <= '0;
			p_q       <= '0;
			row_q     <= '0;
			col_q     <= '0;
			acc_q     <= '0;
			rkk_q     <= '0;
			mq_q      <= '0;
			a_q       <= '0;
			d_q       <= '0;
			q_q       <= '0;
		end else begin
			// a beat taken while the next one is loaded keeps valid high
			if (out_vld_q && res_out.ready && (state_q != ST_EM_WT))
				out_vld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (gram_in.last_entry) begin
							cnt_q   <= '0;
							state_q <= ST_INIT;
							if (size_q < 4'd2)
								n_q <= 4'd2;
							else if (size_q > gsq_pkg::N_W'(gsq_pkg::MAX_DIM))
								n_q <= gsq_pkg::N_W'(gsq_pkg::MAX_DIM);
							else
								n_q <= size_q;
						end else if (cnt_q < gsq_pkg::LOAD_W'(gsq_pkg::ENTRIES)) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_INIT: begin
					ov_q    <= 1'b0;
					state_q <= ST_R00;
				end
				ST_R00: begin
					k_q     <= XW'(1);
					i_q     <= '0;
					l_q     <= '0;
					acc_q   <= '0;
					state_q <= ST_P1_RD;
				end
				ST_P1_RD:  state_q <= ST_P1_MUL;
				ST_P1_MUL: state_q <= ST_P1_SCL;
				ST_P1_SCL, ST_P3_SCL, ST_P3_SCL2: begin
					mq_q <= qs.val;
					ov_q <= ov_q | qs.ovf;
					state_q <= (state_q == ST_P1_SCL) ? ST_P1_ACC :
					           (state_q == ST_P3_SCL) ? ST_P3_ACC : ST_P3_ACC2;
				end
				ST_P1_ACC: begin
					ov_q <= ov_q | sa.ovf;
					if (l_q == i_q) begin
						acc_q <= '0;
						l_q   <= '0;
						if (i_q == km1) begin
							j_q     <= '0;
							i_q     <= '0;
							state_q <= ST_P2_RDD;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_P1_RD;
						end
					end else begin
						acc_q   <= sa.val;
						l_q     <= l_q + 1'b1;
						state_q <= ST_P1_RD;
					end
				end
				ST_P2_RDD: state_q <= ST_P2_CHK;
				ST_P2_CHK: begin
					d_q <= r_eff;
					if (skip) begin
						state_q <= ST_P2_NXT;
					end else if (r_eff == '0) begin
						ov_q    <= 1'b1;
						state_q <= ST_P2_NXT;
					end else begin
						state_q <= ST_P2_GA;
					end
				end
				ST_P2_GA: begin
					a_q     <= r_eff;
					state_q <= ST_P2_GB;
				end
				ST_P2_GB:  state_q <= ST_P2_DIV;
				ST_P2_DIV: state_q <= ST_P2_DWT;
				ST_P2_DWT: begin
					if (div_rsp.done) begin
						q_q     <= div_rsp.quot;
						ov_q    <= ov_q | div_rsp.ovf;
						state_q <= ST_P2_SUB;
					end
				end
				ST_P2_SUB: begin
					acc_q   <= ss.val;
					ov_q    <= ov_q | ss.ovf;
					state_q <= ST_P2_NXT;
				end
				ST_P2_NXT: begin
					if (i_q == km1) begin
						acc_q <= '0;
						if (j_q == km1) begin
							l_q     <= '0;
							p_q     <= '0;
							rkk_q   <= '0;
							state_q <= ST_P3_RD;
						end else begin
							j_q     <= j_q + 1'b1;
							i_q     <= j_q + 1'b1;
							state_q <= ST_P2_RDD;
						end
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_P2_RDD;
					end
				end
				ST_P3_RD:  state_q <= ST_P3_MUL;
				ST_P3_MUL: state_q <= ST_P3_SCL;
				ST_P3_ACC: begin
					acc_q <= sa.val;
					ov_q  <= ov_q | sa.ovf;
					if (p_q == k_q) begin
						state_q <= ST_P3_RDL;
					end else begin
						p_q     <= p_q + 1'b1;
						state_q <= ST_P3_RD;
					end
				end
				ST_P3_RDL:  state_q <= ST_P3_MUL2;
				ST_P3_MUL2: state_q <= ST_P3_SCL2;
				ST_P3_ACC2: begin
					rkk_q <= sk.val;
					ov_q  <= ov_q | sk.ovf;
					acc_q <= '0;
					p_q   <= '0;
					if (l_q == k_q) begin
						l_q <= '0;
						if (k_q == nm1) begin
							row_q   <= '0;
							col_q   <= '0;
							state_q <= ST_EM_RD;
						end else begin
							k_q     <= k_q + 1'b1;
							i_q     <= '0;
							state_q <= ST_P1_RD;
						end
					end else begin
						l_q     <= l_q + 1'b1;
						state_q <= ST_P3_RD;
					end
				end
				ST_EM_RD: state_q <= ST_EM_WT;
				ST_EM_WT: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						if (em_last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_EM_RD;
							if (col_q == nm1) begin
								col_q <= '0;
								row_q <= row_q + 1'b1;
							end else begin
								col_q <= col_q + 1'b1;
							end
						end
					end else if (res_out.ready) begin
						out_vld_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_EM_WT) && out_free) begin
			orow_q  <= row_q;
			ocol_q  <= col_q;
			or_q    <= r_eff;
			oc_q    <= c_eff;
			oov_q   <= ov_q;
			olast_q <= em_last;
		end
	end

	assign res_out.valid       = out_vld_q;
	assign res_out.row_index   = orow_q;
	assign res_out.col_index   = ocol_q;
	assign res_out.r_value     = or_q;
	assign res_out.c_value     = oc_q;
	assign res_out.overflow    = oov_q;
	assign res_out.last_result = olast_q;

	`GSQ_ASSERT(a_mark_starts, clk, arst_n, (in_acc && gram_in.last_entry) |=> (state_q == ST_INIT), "marked beat did not start a run")
	`GSQ_ASSERT(a_div_owner, clk, arst_n, div_rsp.done |-> (state_q == ST_P2_DWT), "divider result with no waiting term")
	`GSQ_ASSERT(a_div_nonzero, clk, arst_n, div_req.start |-> (div_req.divisor != '0), "divider started on a zero divisor")
	`GSQ_NEVER(a_no_write_emit, clk, arst_n, (we_r || we_c) && ((state_q == ST_EM_RD) || (state_q == ST_EM_WT)), "factor memory written while results stream out")

endmodule

### sv/gsq_div.sv
// Bit-serial signed divider for the Q32.32 by Q16.16 division terms.
`timescale 1ns / 1ps
module gsq_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gsq_pkg::div_req_t req,
	output gsq_pkg::div_rsp_t rsp
);

	logic                                  busy_q;
	logic                                  fin_q;
	logic                                  done_q;
	logic [gsq_pkg::DIV_CNT_W-1:0]         cnt_q;
	logic [62:0]                           work_q;
	logic [31:0]                           rem_q;
	logic [31:0]                           dvs_q;
	logic                                  neg_q;
	logic                                  ovf_q;
	logic signed [gsq_pkg::DATA_W-1:0]     quot_q;

	logic [63:0]        dvd_abs;
	logic [32:0]        dvs_abs;
	logic [32:0]        shifted;
	logic               ge;
	logic [64:0]        qwide;
	gsq_pkg::sat_t      fin_sat;

	always_comb begin
		dvd_abs = req.dividend[63] ? 64'(-req.dividend) : 64'(req.dividend);
		dvs_abs = req.divisor[31] ? 33'(-$signed({req.divisor[31], req.divisor}))
		                          : {1'b0, req.divisor};
		shifted = {rem_q, work_q[62]};
		ge      = shifted >= {1'b0, dvs_q};
		qwide   = neg_q ? 65'(-$signed({2'b00, work_q})) : {2'b00, work_q};
		fin_sat = gsq_pkg::sat65($signed(qwide));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q  <= 1'b0;
			done_q <= fin_q;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == gsq_pkg::DIV_CNT_W'(gsq_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= dvd_abs[62:0];
			rem_q  <= '0;
			dvs_q  <= dvs_abs[31:0];
			neg_q  <= req.dividend[63] ^ req.divisor[31];
		end else if (busy_q) begin
			rem_q  <= ge ? 32'(shifted - {1'b0, dvs_q}) : shifted[31:0];
			work_q <= {work_q[61:0], ge};
		end
		if (fin_q) begin
			quot_q <= fin_sat.val;
			ovf_q  <= fin_sat.ovf;
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.quot = quot_q;

endmodule
